[hw/rtl/radio_command_framer_core_assert.svh]
// Assertion macros shared by the framer modules.
// Each module that uses them has i_clk and i_rst_n in scope.
`ifndef RADIO_COMMAND_FRAMER_CORE_ASSERT_SVH
`define RADIO_COMMAND_FRAMER_CORE_ASSERT_SVH

// Same-cycle implication, checked outside reset
`define RCF_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("rcf: same-cycle check failed");

// Next-cycle implication, checked outside reset
`define RCF_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("rcf: next-cycle check failed");

`endif

[hw/rtl/rcf_pkg.sv]
package rcf_pkg;

    // Frame constants
    localparam logic [7:0] SYNC0   = 8'h48;
    localparam logic [7:0] SYNC1   = 8'h65;
    localparam logic [7:0] PREFIX  = 8'h10;
    localparam logic [7:0] LEN_MSB = 8'h00;

    // Input opcodes
    localparam logic OP_HEADER = 1'b0;
    localparam logic OP_DATA   = 1'b1;

    // Byte positions inside a header run
    localparam logic [2:0] STEP_SYNC0  = 3'd0;
    localparam logic [2:0] STEP_SYNC1  = 3'd1;
    localparam logic [2:0] STEP_PREFIX = 3'd2;
    localparam logic [2:0] STEP_CMD    = 3'd3;
    localparam logic [2:0] STEP_LENH   = 3'd4;
    localparam logic [2:0] STEP_LENL   = 3'd5;
    localparam logic [2:0] STEP_CKA    = 3'd6;
    localparam logic [2:0] STEP_CKB    = 3'd7;

    // Byte positions inside a final payload run
    localparam logic [2:0] STEP_DATA  = 3'd0;
    localparam logic [2:0] STEP_SUM_A = 3'd1;
    localparam logic [2:0] STEP_SUM_B = 3'd2;

    // Work classes handed from front to back
    typedef enum logic [1:0] {
        KIND_HEADER = 2'd0,
        KIND_DATA   = 2'd1,
        KIND_LAST   = 2'd2,
        KIND_STRAY  = 2'd3
    } t_kind;

    // Queue entry: byte0 = command or payload byte, byte1 = length,
    // sum_a/sum_b = header checksum or closing running sums
    typedef struct packed {
        t_kind      kind;
        logic [7:0] byte0;
        logic [7:0] byte1;
        logic [7:0] sum_a;
        logic [7:0] sum_b;
    } t_cmd;

    typedef struct packed {
        logic       opcode;
        logic [7:0] command_code;
        logic [7:0] payload_length;
        logic [7:0] data_byte;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       end_of_frame;
        logic       last_of_run;
        logic       stray_byte;
    } t_out_item;

    // Queue status seen by the front and back
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

[hw/rtl/rcf_stream_if.sv]
interface rcf_stream_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

[hw/rtl/rcf_front.sv]
`include "radio_command_framer_core_assert.svh"

module rcf_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    rcf_stream_if.sink            i_in,
    input  rcf_pkg::t_q_status    i_q_status,
    output logic                  o_push,
    output rcf_pkg::t_cmd         o_cmd
);

    logic       r_in_frame, n_in_frame;
    logic [7:0] r_remaining, n_remaining;
    logic [7:0] r_sum_a, n_sum_a;
    logic [7:0] r_sum_b, n_sum_b;

    logic       accept;
    logic [7:0] hdr_a, hdr_b;
    logic [7:0] run_a, run_b;
    logic [7:0] dat_a, dat_b;
    logic [7:0] rem_dec;

    assign i_in.ready = !i_q_status.full;
    assign accept     = i_in.valid && i_in.ready;
    assign o_push     = accept;

    // Header checksum over prefix, command, length MSB, length LSB,
    // then keep the running sums going over the two checksum bytes
    always_comb begin
        logic [7:0] a1, b1, a2, b2, a3, b3, a4;
        a1    = rcf_pkg::PREFIX;
        b1    = rcf_pkg::PREFIX;
        a2    = a1 + i_in.payload.command_code;
        b2    = b1 + a2;
        a3    = a2 + rcf_pkg::LEN_MSB;
        b3    = b2 + a3;
        hdr_a = a3 + i_in.payload.payload_length;
        hdr_b = b3 + hdr_a;
        a4    = hdr_a + hdr_a;
        run_a = a4 + hdr_b;
        run_b = (hdr_b + a4) + run_a;
    end

    // Payload byte update of the running sums
    assign dat_a   = r_sum_a + i_in.payload.data_byte;
    assign dat_b   = r_sum_b + dat_a;
    assign rem_dec = r_remaining - 8'd1;

    // Classify the item and work out the next state
    always_comb begin
        n_in_frame  = r_in_frame;
        n_remaining = r_remaining;
        n_sum_a     = r_sum_a;
        n_sum_b     = r_sum_b;
        o_cmd.kind  = rcf_pkg::KIND_STRAY;
        o_cmd.byte0 = i_in.payload.data_byte;
        o_cmd.byte1 = i_in.payload.payload_length;
        o_cmd.sum_a = dat_a;
        o_cmd.sum_b = dat_b;
        if (i_in.payload.opcode == rcf_pkg::OP_HEADER) begin
            o_cmd.kind  = rcf_pkg::KIND_HEADER;
            o_cmd.byte0 = i_in.payload.command_code;
            o_cmd.sum_a = hdr_a;
            o_cmd.sum_b = hdr_b;
            if (accept) begin
                n_in_frame  = (i_in.payload.payload_length != 8'd0);
                n_remaining = i_in.payload.payload_length;
                n_sum_a     = run_a;
                n_sum_b     = run_b;
            end
        end else if (r_in_frame) begin
            o_cmd.kind = (rem_dec == 8'd0) ? rcf_pkg::KIND_LAST : rcf_pkg::KIND_DATA;
            if (accept) begin
                n_in_frame  = (rem_dec != 8'd0);
                n_remaining = rem_dec;
                n_sum_a     = dat_a;
                n_sum_b     = dat_b;
            end
        end
    end

    // Hold frame state between transfers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_frame  <= 1'b0;
            r_remaining <= 8'd0;
            r_sum_a     <= 8'd0;
            r_sum_b     <= 8'd0;
        end else begin
            r_in_frame  <= n_in_frame;
            r_remaining <= n_remaining;
            r_sum_a     <= n_sum_a;
            r_sum_b     <= n_sum_b;
        end
    end

    `RCF_ASSERT_NOW(a_idle_no_count, !r_in_frame, r_remaining == 8'd0)

endmodule

[hw/rtl/rcf_cmd_fifo.sv]
`include "radio_command_framer_core_assert.svh"

module rcf_cmd_fifo #(
    parameter int DEPTH = 4
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  rcf_pkg::t_cmd      i_cmd,
    input  logic               i_pop,
    output rcf_pkg::t_cmd      o_head,
    output rcf_pkg::t_q_status o_status
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    rcf_pkg::t_cmd    r_mem [DEPTH];
    logic [PTR_W-1:0] r_wptr, n_wptr;
    logic [PTR_W-1:0] r_rptr, n_rptr;
    logic [CNT_W-1:0] r_count, n_count;

    assign o_status.full  = (r_count == CNT_FULL);
    assign o_status.empty = (r_count == '0);
    assign o_head         = r_mem[r_rptr];

    // Advance pointers and occupancy
    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (i_push) begin
            n_wptr = (r_wptr == PTR_LAST) ? '0 : r_wptr + 1'b1;
        end
        if (i_pop) begin
            n_rptr = (r_rptr == PTR_LAST) ? '0 : r_rptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    // Store entries
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_cmd;
        end
    end

    `RCF_ASSERT_NOW(a_no_overflow, o_status.full, !i_push)
    `RCF_ASSERT_NOW(a_no_underflow, o_status.empty, !i_pop)

endmodule

[hw/rtl/rcf_back.sv]
`include "radio_command_framer_core_assert.svh"

module rcf_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  rcf_pkg::t_cmd      i_head,
    input  rcf_pkg::t_q_status i_q_status,
    output logic               o_pop,
    rcf_stream_if.source       o_out
);

    logic [2:0]         r_step, n_step;
    logic               r_out_valid, n_out_valid;
    rcf_pkg::t_out_item r_out;
    rcf_pkg::t_out_item next_item;
    logic               emit;
    logic               last_step;

    assign emit  = !i_q_status.empty && (!r_out_valid || o_out.ready);
    assign o_pop = emit && last_step;

    // Pick the byte for the current position of the head entry
    always_comb begin
        next_item              = '0;
        last_step              = 1'b1;
        unique case (i_head.kind)
            rcf_pkg::KIND_HEADER: begin
                last_step              = (r_step == rcf_pkg::STEP_CKB);
                next_item.last_of_run  = last_step;
                next_item.end_of_frame = last_step && (i_head.byte1 == 8'd0);
                unique case (r_step)
                    rcf_pkg::STEP_SYNC0:  next_item.out_byte = rcf_pkg::SYNC0;
                    rcf_pkg::STEP_SYNC1:  next_item.out_byte = rcf_pkg::SYNC1;
                    rcf_pkg::STEP_PREFIX: next_item.out_byte = rcf_pkg::PREFIX;
                    rcf_pkg::STEP_CMD:    next_item.out_byte = i_head.byte0;
                    rcf_pkg::STEP_LENH:   next_item.out_byte = rcf_pkg::LEN_MSB;
                    rcf_pkg::STEP_LENL:   next_item.out_byte = i_head.byte1;
                    rcf_pkg::STEP_CKA:    next_item.out_byte = i_head.sum_a;
                    rcf_pkg::STEP_CKB:    next_item.out_byte = i_head.sum_b;
                    default:              next_item.out_byte = i_head.sum_b;
                endcase
            end
            rcf_pkg::KIND_LAST: begin
                last_step              = (r_step == rcf_pkg::STEP_SUM_B);
                next_item.last_of_run  = last_step;
                next_item.end_of_frame = last_step;
                if (r_step == rcf_pkg::STEP_DATA) begin
                    next_item.out_byte = i_head.byte0;
                end else if (r_step == rcf_pkg::STEP_SUM_A) begin
                    next_item.out_byte = i_head.sum_a;
                end else begin
                    next_item.out_byte = i_head.sum_b;
                end
            end
            rcf_pkg::KIND_DATA: begin
                next_item.out_byte    = i_head.byte0;
                next_item.last_of_run = 1'b1;
            end
            rcf_pkg::KIND_STRAY: begin
                next_item.last_of_run = 1'b1;
                next_item.stray_byte  = 1'b1;
            end
            default: begin
                next_item.last_of_run = 1'b1;
            end
        endcase
    end

    // Advance the position and the output register
    always_comb begin
        n_step      = r_step;
        n_out_valid = r_out_valid;
        if (emit) begin
            n_step      = last_step ? '0 : r_step + 3'd1;
            n_out_valid = 1'b1;
        end else if (o_out.ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
    end

    // Load the payload on each transfer into the output register
    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out <= next_item;
        end
    end

    assign o_out.valid   = r_out_valid;
    assign o_out.payload = r_out;

    `RCF_ASSERT_NOW(a_step_has_head, r_step != 3'd0, !i_q_status.empty)
    `RCF_ASSERT_NEXT(a_stray_single, emit && (i_head.kind == rcf_pkg::KIND_STRAY),
        r_out.last_of_run && !r_out.end_of_frame)

endmodule

[hw/rtl/radio_command_framer_core.sv]
// Channel | Dir | Payload                                          | Handshake
// i_in    | in  | opcode, command_code, payload_length, data_byte  | valid/ready
// o_out   | out | out_byte, end_of_frame, last_of_run, stray_byte  | valid/ready
//
// Payload and stray items yield one byte each, a header eight, a final payload
// byte three; the back sequencer emits a byte a cycle when queue and sink allow.
// The front takes an item every cycle while the command queue has room.
// A queue of FIFO_DEPTH entries parts the front from the back; the output
// register holds a byte until the sink takes it.
// Reset is synchronous and active low; it empties the queue and clears
// frame state and the output valid.
module radio_command_framer_core #(
    parameter int FIFO_DEPTH = 4
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    rcf_stream_if.sink   i_in,
    rcf_stream_if.source o_out
);

    logic               push;
    logic               pop;
    rcf_pkg::t_cmd      push_cmd;
    rcf_pkg::t_cmd      head_cmd;
    rcf_pkg::t_q_status q_status;

    rcf_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (i_in),
        .i_q_status (q_status),
        .o_push     (push),
        .o_cmd      (push_cmd)
    );

    rcf_cmd_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_cmd    (push_cmd),
        .i_pop    (pop),
        .o_head   (head_cmd),
        .o_status (q_status)
    );

    rcf_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_head     (head_cmd),
        .i_q_status (q_status),
        .o_pop      (pop),
        .o_out      (o_out)
    );

endmodule

[verif/radio_command_framer_core_test.sv]
module radio_command_framer_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    // One queued input transfer; hold_for_drain keeps it back until
    // every byte predicted so far has left the block
    typedef struct {
        rcf_pkg::t_in_item item;
        bit                hold_for_drain;
    } t_send_entry;

    logic i_clk;
    logic i_rst_n;

    rcf_stream_if #(.t_payload(rcf_pkg::t_in_item))  in_ch ();
    rcf_stream_if #(.t_payload(rcf_pkg::t_out_item)) out_ch ();

    radio_command_framer_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    t_send_entry        send_q [$];
    rcf_pkg::t_out_item frame_bytes_q [$];

    // Framer state as the predictor sees it
    bit         frame_open;
    logic [7:0] bytes_left;
    logic [7:0] run_a;
    logic [7:0] run_b;

    int mismatch_count = 0;
    int results_seen;
    int hold_left;
    bit hold_done;
    int tx_wait;
    int rx_wait;
    bit tx_calm;
    bit rx_calm;

    always #4 i_clk = ~i_clk;

    // Fold one byte into the running Fletcher sums
    task automatic fold_byte(input logic [7:0] v);
        run_a = run_a + v;
        run_b = run_b + run_a;
    endtask

    task automatic push_frame_byte(input logic [7:0] b, input bit eof, input bit last,
                                   input bit stray);
        rcf_pkg::t_out_item r;
        r.out_byte     = b;
        r.end_of_frame = eof;
        r.last_of_run  = last;
        r.stray_byte   = stray;
        frame_bytes_q.push_back(r);
    endtask

    // Work out the framed bytes that one accepted input transfer causes
    task automatic predict_frame_bytes(input rcf_pkg::t_in_item it);
        logic [7:0] hdr [8];
        int         k;
        if (it.opcode == rcf_pkg::OP_HEADER) begin
            hdr[rcf_pkg::STEP_SYNC0]  = rcf_pkg::SYNC0;
            hdr[rcf_pkg::STEP_SYNC1]  = rcf_pkg::SYNC1;
            hdr[rcf_pkg::STEP_PREFIX] = rcf_pkg::PREFIX;
            hdr[rcf_pkg::STEP_CMD]    = it.command_code;
            hdr[rcf_pkg::STEP_LENH]   = rcf_pkg::LEN_MSB;
            hdr[rcf_pkg::STEP_LENL]   = it.payload_length;
            // restart the sums at the prefix; an open frame is dropped
            run_a = 8'h00;
            run_b = 8'h00;
            for (k = rcf_pkg::STEP_PREFIX; k <= rcf_pkg::STEP_LENL; k++)
                fold_byte(hdr[k]);
            hdr[rcf_pkg::STEP_CKA] = run_a;
            hdr[rcf_pkg::STEP_CKB] = run_b;
            fold_byte(hdr[rcf_pkg::STEP_CKA]);
            fold_byte(hdr[rcf_pkg::STEP_CKB]);
            for (k = rcf_pkg::STEP_SYNC0; k <= rcf_pkg::STEP_CKB; k++)
                push_frame_byte(hdr[k],
                                (it.payload_length == 8'd0) && (k == rcf_pkg::STEP_CKB),
                                k == rcf_pkg::STEP_CKB, 1'b0);
            frame_open = (it.payload_length != 8'd0);
            bytes_left = it.payload_length;
        end else if (!frame_open) begin
            // data outside a frame: drop it and flag it
            push_frame_byte(8'h00, 1'b0, 1'b1, 1'b1);
        end else begin
            fold_byte(it.data_byte);
            bytes_left = bytes_left - 8'd1;
            if (bytes_left != 8'd0) begin
                push_frame_byte(it.data_byte, 1'b0, 1'b1, 1'b0);
            end else begin
                push_frame_byte(it.data_byte, 1'b0, 1'b0, 1'b0);
                push_frame_byte(run_a, 1'b0, 1'b0, 1'b0);
                push_frame_byte(run_b, 1'b1, 1'b1, 1'b0);
                frame_open = 1'b0;
            end
        end
    endtask

    function automatic void flag_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("mismatch at %0t: %s", $realtime, msg);
    endfunction

    // Compare one output transfer with the oldest predicted byte
    task automatic check_frame_byte(input rcf_pkg::t_out_item got);
        rcf_pkg::t_out_item want;
        if (frame_bytes_q.size() == 0) begin
            flag_mismatch($sformatf("unexpected byte %02h eof %0b last %0b stray %0b",
                                    got.out_byte, got.end_of_frame, got.last_of_run,
                                    got.stray_byte));
        end else begin
            want = frame_bytes_q.pop_front();
            if (got.out_byte !== want.out_byte)
                flag_mismatch($sformatf("out_byte expected %02h got %02h",
                                        want.out_byte, got.out_byte));
            if (got.end_of_frame !== want.end_of_frame)
                flag_mismatch($sformatf("end_of_frame expected %0b got %0b",
                                        want.end_of_frame, got.end_of_frame));
            if (got.last_of_run !== want.last_of_run)
                flag_mismatch($sformatf("last_of_run expected %0b got %0b",
                                        want.last_of_run, got.last_of_run));
            if (got.stray_byte !== want.stray_byte)
                flag_mismatch($sformatf("stray_byte expected %0b got %0b",
                                        want.stray_byte, got.stray_byte));
        end
    endtask

    task automatic queue_item(input logic op, input logic [7:0] cmd, input logic [7:0] len,
                              input logic [7:0] dat, input bit drain);
        t_send_entry e;
        e.item.opcode         = op;
        e.item.command_code   = cmd;
        e.item.payload_length = len;
        e.item.data_byte      = dat;
        e.hold_for_drain      = drain;
        send_q.push_back(e);
    endtask

    // Header with random content, then sent_cnt random payload bytes
    task automatic queue_frame(input logic [7:0] len, input int sent_cnt, input bit drain);
        int k;
        queue_item(rcf_pkg::OP_HEADER, 8'($urandom), len, 8'($urandom), drain);
        for (k = 0; k < sent_cnt; k++)
            queue_item(rcf_pkg::OP_DATA, 8'($urandom), 8'($urandom), 8'($urandom), 1'b0);
    endtask

    // Driver: offer queued transfers with a random gap after each one
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
            tx_wait = 0;
        end else if (!(in_ch.valid && !in_ch.ready)) begin
            if (in_ch.valid) begin
                predict_frame_bytes(in_ch.payload);
                tx_wait = tx_calm ? 0 : $urandom_range(0, 5);
                if ($urandom_range(0, 63) == 0)
                    tx_calm = !tx_calm;
            end
            if (tx_wait > 0) begin
                tx_wait--;
                in_ch.valid <= 1'b0;
            end else if (send_q.size() != 0 &&
                         !(send_q[0].hold_for_drain && frame_bytes_q.size() != 0)) begin
                in_ch.payload <= send_q[0].item;
                in_ch.valid   <= 1'b1;
                void'(send_q.pop_front());
            end else begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    // Monitor: check each output transfer, then idle for a random count
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
            results_seen <= 0;
            rx_wait = 0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                check_frame_byte(out_ch.payload);
                results_seen <= results_seen + 1;
                rx_wait = rx_calm ? 0 : $urandom_range(0, 5);
                if ($urandom_range(0, 63) == 0)
                    rx_calm = !rx_calm;
            end
            if (rx_wait > 0) begin
                rx_wait--;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= (hold_left == 0);
            end
        end
    end

    // Hold off the receiver once for a long stretch so the block backs up
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end else if (!hold_done && results_seen >= 300) begin
            hold_left <= 400;
            hold_done <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    initial begin
        int  pick;
        int  len;
        int  total;
        bit  big_done;
        i_clk         = 1'b0;
        i_rst_n       = 1'b0;
        in_ch.valid   = 1'b0;
        in_ch.payload = '0;
        out_ch.ready  = 1'b0;
        frame_open    = 1'b0;
        bytes_left    = 8'h00;
        run_a         = 8'h00;
        run_b         = 8'h00;
        tx_calm       = 1'b0;
        rx_calm       = 1'b0;
        big_done      = 1'b0;

        // Directed: stray bytes, empty frames, short frames, abandoned frames
        queue_item(rcf_pkg::OP_DATA,   8'h00, 8'h00, 8'h00, 1'b0);
        queue_item(rcf_pkg::OP_DATA,   8'hFF, 8'hFF, 8'hFF, 1'b0);
        queue_item(rcf_pkg::OP_HEADER, 8'h01, 8'h00, 8'h00, 1'b0);
        queue_item(rcf_pkg::OP_HEADER, 8'h07, 8'h00, 8'hFF, 1'b0);
        queue_item(rcf_pkg::OP_HEADER, 8'h00, 8'h00, 8'h00, 1'b0);
        queue_item(rcf_pkg::OP_HEADER, 8'hFF, 8'h00, 8'hFF, 1'b0);
        queue_item(rcf_pkg::OP_DATA,   8'h00, 8'h00, 8'h5A, 1'b0);
        queue_item(rcf_pkg::OP_HEADER, 8'h03, 8'h01, 8'h00, 1'b0);
        queue_item(rcf_pkg::OP_DATA,   8'h00, 8'h00, 8'hFF, 1'b0);
        queue_item(rcf_pkg::OP_HEADER, 8'h03, 8'h02, 8'h00, 1'b0);
        queue_item(rcf_pkg::OP_DATA,   8'h00, 8'h00, 8'h00, 1'b0);
        queue_item(rcf_pkg::OP_DATA,   8'h00, 8'h00, 8'hFF, 1'b0);
        queue_item(rcf_pkg::OP_HEADER, 8'h03, 8'h04, 8'h00, 1'b0);
        queue_item(rcf_pkg::OP_DATA,   8'h00, 8'h00, 8'h12, 1'b0);
        queue_item(rcf_pkg::OP_HEADER, 8'h03, 8'h01, 8'h00, 1'b0);
        queue_item(rcf_pkg::OP_DATA,   8'h00, 8'h00, 8'h80, 1'b0);
        queue_item(rcf_pkg::OP_DATA,   8'h00, 8'h00, 8'h33, 1'b0);
        queue_item(rcf_pkg::OP_HEADER, 8'hFF, 8'hFF, 8'hFF, 1'b0);
        queue_item(rcf_pkg::OP_DATA,   8'hFF, 8'hFF, 8'hFF, 1'b0);
        queue_item(rcf_pkg::OP_DATA,   8'hFF, 8'hFF, 8'hFF, 1'b0);
        queue_item(rcf_pkg::OP_HEADER, 8'hAA, 8'h03, 8'h00, 1'b0);
        queue_item(rcf_pkg::OP_DATA,   8'h00, 8'h00, 8'hF0, 1'b0);
        queue_item(rcf_pkg::OP_DATA,   8'h00, 8'h00, 8'hF1, 1'b0);
        queue_item(rcf_pkg::OP_DATA,   8'h00, 8'h00, 8'hF2, 1'b0);

        // Random: mostly complete frames, some strays and cut-off frames,
        // and one full-length frame sent after the block has drained
        total = send_q.size();
        queue_frame(8'd2, 2, 1'b1);
        while (total < 460) begin
            pick = $urandom_range(0, 99);
            if (!big_done && total >= 150) begin
                queue_frame(8'd255, 255, 1'b1);
                big_done = 1'b1;
            end else if (pick < 8) begin
                queue_item(rcf_pkg::OP_DATA, 8'($urandom), 8'($urandom), 8'($urandom), 1'b0);
            end else if (pick < 18) begin
                len = $urandom_range(1, 255);
                queue_frame(8'(len), $urandom_range(0, (len > 5) ? 4 : len - 1), 1'b0);
            end else begin
                len = ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, 10);
                queue_frame(8'(len), len, 1'b0);
            end
            total = send_q.size();
        end

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Wait for the last transfer in and every predicted byte out;
        // sample between edges so the driver's updates have settled
        while (send_q.size() != 0 || in_ch.valid || frame_bytes_q.size() != 0)
            @(negedge i_clk);
        repeat (40) @(posedge i_clk);

        if (mismatch_count == 0 && frame_bytes_q.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #5000000;
        $display("tb: failure");
        $finish;
    end

endmodule
